// ===== rtl/cse_pkg.sv =====
package cse_pkg;

    localparam int DEF_MAX_ITEMS   = 1024;
    localparam int DEF_COUNT_DEPTH = 1024;
    localparam int DEF_VALUE_BITS  = 16;

    localparam int ITEM_COUNT_BITS = 11;
    localparam int KIND_BITS       = 2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_STATUS  = 2'd0,
        KIND_ELEMENT = 2'd1,
        KIND_EMPTY   = 2'd2
    } kind_t;

endpackage

// ===== rtl/cse_ram.sv =====
module cse_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/counting_sort_engine.sv =====
// Channel   Handshake                Payload
// -------   ----------------------   ----------------------------------------------------
// config    cfg_we                   cfg_wdata (min_is_zero)
// input     in_valid / in_ready      operation, value, last
// output    out_valid / out_ready    kind, sorted_value, final_element, range_error,
//                                    item_count
//
// A load without last keeps the sequencer idle; a fetch passes through the emit state,
// which waits out any output stall. A load with last checks the range and, if it passes,
// sorts through the count table's single read and write port (clear, count, prefix, place).
// in_ready is high only while the sequencer is idle; the output register holds one item.
// Reset (rst_n, asynchronous) empties the batch; memories keep old contents and are
// never read before being written.
module counting_sort_engine #(
    parameter int MAX_ITEMS   = cse_pkg::DEF_MAX_ITEMS,
    parameter int COUNT_DEPTH = cse_pkg::DEF_COUNT_DEPTH,
    parameter int VALUE_BITS  = cse_pkg::DEF_VALUE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                operation,
    input  logic signed [VALUE_BITS-1:0]        value,
    input  logic                                last,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [cse_pkg::KIND_BITS-1:0]       kind,
    output logic signed [VALUE_BITS-1:0]        sorted_value,
    output logic                                final_element,
    output logic                                range_error,
    output logic [cse_pkg::ITEM_COUNT_BITS-1:0] item_count
);

    import cse_pkg::*;

    localparam int AW     = $clog2(MAX_ITEMS);
    localparam int HW     = $clog2(MAX_ITEMS + 1);
    localparam int CW     = HW;
    localparam int KW     = $clog2(COUNT_DEPTH);
    localparam int IDX_W  = (AW > KW) ? AW : KW;
    localparam int SPAN_W = ((VALUE_BITS > KW) ? VALUE_BITS : KW) + 2;
    localparam int KCW    = ((VALUE_BITS > KW) ? VALUE_BITS : KW) + 1;

    localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic signed [SPAN_W-1:0]     SPAN_MAX = SPAN_W'(COUNT_DEPTH - 1);
    localparam logic [IDX_W-1:0]             IDX_END  = IDX_W'(COUNT_DEPTH - 1);

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_CHECK   = 12'b0000_0000_0010,
        S_CLEAR   = 12'b0000_0000_0100,
        S_CNT_RD  = 12'b0000_0000_1000,
        S_CNT_KEY = 12'b0000_0001_0000,
        S_CNT_WR  = 12'b0000_0010_0000,
        S_PRE_RD  = 12'b0000_0100_0000,
        S_PRE_WR  = 12'b0000_1000_0000,
        S_PL_RD   = 12'b0001_0000_0000,
        S_PL_KEY  = 12'b0010_0000_0000,
        S_PL_WR   = 12'b0100_0000_0000,
        S_EMIT    = 12'b1000_0000_0000
    } state_t;

    state_t                         state_reg, state_next;
    logic [IDX_W-1:0]               idx_reg, idx_next;
    logic [HW-1:0]                  held_reg, held_next;
    logic signed [VALUE_BITS-1:0]   min_reg, min_next;
    logic signed [VALUE_BITS-1:0]   max_reg, max_next;
    logic [HW-1:0]                  fp_reg, fp_next;
    logic                           err_reg, err_next;
    logic                           done_reg, done_next;
    logic                           mz_reg;
    logic                           out_valid_reg, out_valid_next;

    logic signed [VALUE_BITS-1:0]   lo_reg, lo_next;
    logic [AW-1:0]                  last_idx_reg, last_idx_next;
    logic [KW-1:0]                  key_reg, key_next;
    logic [CW-1:0]                  acc_reg, acc_next;
    kind_t                          pend_kind_reg, pend_kind_next;
    logic                           pend_final_reg, pend_final_next;
    kind_t                          kind_reg, kind_next;
    logic signed [VALUE_BITS-1:0]   sval_reg, sval_next;
    logic                           final_reg, final_next;
    logic                           rerr_reg, rerr_next;
    logic [ITEM_COUNT_BITS-1:0]     count_reg, count_next;

    logic                           val_we, val_re;
    logic [AW-1:0]                  val_waddr, val_raddr;
    logic [VALUE_BITS-1:0]          val_wdata, val_rdata;
    logic                           cnt_we, cnt_re;
    logic [KW-1:0]                  cnt_waddr, cnt_raddr;
    logic [CW-1:0]                  cnt_wdata, cnt_rdata;
    logic                           srt_we, srt_re;
    logic [AW-1:0]                  srt_waddr, srt_raddr;
    logic [VALUE_BITS-1:0]          srt_wdata, srt_rdata;

    logic [HW-1:0]                  held_base;
    logic signed [VALUE_BITS-1:0]   min_base, max_base;
    logic                           err_base;
    logic signed [VALUE_BITS-1:0]   lo_sel;
    logic signed [SPAN_W-1:0]       span;
    logic                           check_err;
    logic signed [KCW-1:0]          key_diff;
    logic [KW-1:0]                  key;
    logic [CW-1:0]                  prefix_sum;
    logic [CW-1:0]                  pos;
    logic                           fetch_avail;
    logic                           out_free;

    cse_ram #(.DEPTH(MAX_ITEMS), .WIDTH(VALUE_BITS), .ADDR_W(AW)) u_value_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .re    (val_re),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    cse_ram #(.DEPTH(COUNT_DEPTH), .WIDTH(CW), .ADDR_W(KW)) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    cse_ram #(.DEPTH(MAX_ITEMS), .WIDTH(VALUE_BITS), .ADDR_W(AW)) u_sorted_ram (
        .clk   (clk),
        .we    (srt_we),
        .waddr (srt_waddr),
        .wdata (srt_wdata),
        .re    (srt_re),
        .raddr (srt_raddr),
        .rdata (srt_rdata)
    );

    assign held_base   = done_reg ? '0 : held_reg;
    assign min_base    = done_reg ? VAL_MAX : min_reg;
    assign max_base    = done_reg ? VAL_MIN : max_reg;
    assign err_base    = done_reg ? 1'b0 : err_reg;

    assign lo_sel      = mz_reg ? '0 : min_reg;
    assign span        = SPAN_W'(max_reg) - SPAN_W'(lo_sel);
    assign check_err   = err_reg | (mz_reg & min_reg[VALUE_BITS-1]) | (span > SPAN_MAX);

    assign key_diff    = KCW'($signed(val_rdata)) - KCW'(lo_reg);
    assign key         = key_diff[KW-1:0];
    assign prefix_sum  = cnt_rdata + acc_reg;
    assign pos         = cnt_rdata - CW'(1);

    assign fetch_avail = done_reg & ~err_reg & (fp_reg < held_reg);
    assign out_free    = ~out_valid_reg | out_ready;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        held_next       = held_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        fp_next         = fp_reg;
        err_next        = err_reg;
        done_next       = done_reg;
        lo_next         = lo_reg;
        last_idx_next   = last_idx_reg;
        key_next        = key_reg;
        acc_next        = acc_reg;
        pend_kind_next  = pend_kind_reg;
        pend_final_next = pend_final_reg;
        out_valid_next  = out_valid_reg & ~out_ready;
        kind_next       = kind_reg;
        sval_next       = sval_reg;
        final_next      = final_reg;
        rerr_next       = rerr_reg;
        count_next      = count_reg;

        val_we    = 1'b0;
        val_waddr = held_base[AW-1:0];
        val_wdata = value;
        val_re    = 1'b0;
        val_raddr = idx_reg[AW-1:0];
        cnt_we    = 1'b0;
        cnt_waddr = idx_reg[KW-1:0];
        cnt_wdata = '0;
        cnt_re    = 1'b0;
        cnt_raddr = idx_reg[KW-1:0];
        srt_we    = 1'b0;
        srt_waddr = pos[AW-1:0];
        srt_wdata = val_rdata;
        srt_re    = 1'b0;
        srt_raddr = fp_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation == OP_LOAD)
                    begin
                        held_next = held_base;
                        min_next  = min_base;
                        max_next  = max_base;
                        err_next  = err_base;
                        done_next = 1'b0;
                        if (done_reg)
                        begin
                            fp_next = '0;
                        end
                        if (held_base < HW'(MAX_ITEMS))
                        begin
                            val_we    = 1'b1;
                            held_next = held_base + HW'(1);
                            min_next  = (value < min_base) ? value : min_base;
                            max_next  = (value > max_base) ? value : max_base;
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                        if (last)
                        begin
                            state_next = S_CHECK;
                        end
                    end
                    else
                    begin
                        if (fetch_avail)
                        begin
                            srt_re          = 1'b1;
                            pend_kind_next  = KIND_ELEMENT;
                            pend_final_next = (fp_reg + HW'(1)) == held_reg;
                            fp_next         = fp_reg + HW'(1);
                        end
                        else
                        begin
                            pend_kind_next  = KIND_EMPTY;
                            pend_final_next = 1'b0;
                        end
                        state_next = S_EMIT;
                    end
                end
            end

            S_CHECK:
            begin
                lo_next         = lo_sel;
                err_next        = check_err;
                done_next       = 1'b1;
                fp_next         = '0;
                last_idx_next   = AW'(held_reg - HW'(1));
                idx_next        = '0;
                pend_kind_next  = KIND_STATUS;
                pend_final_next = 1'b0;
                state_next      = check_err ? S_EMIT : S_CLEAR;
            end

            S_CLEAR:
            begin
                cnt_we = 1'b1;
                if (idx_reg == IDX_END)
                begin
                    idx_next   = '0;
                    state_next = S_CNT_RD;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_CNT_RD:
            begin
                val_re     = 1'b1;
                state_next = S_CNT_KEY;
            end

            S_CNT_KEY:
            begin
                cnt_re     = 1'b1;
                cnt_raddr  = key;
                key_next   = key;
                state_next = S_CNT_WR;
            end

            S_CNT_WR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = key_reg;
                cnt_wdata = cnt_rdata + CW'(1);
                if (idx_reg[AW-1:0] == last_idx_reg)
                begin
                    idx_next   = '0;
                    acc_next   = '0;
                    state_next = S_PRE_RD;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_CNT_RD;
                end
            end

            S_PRE_RD:
            begin
                cnt_re     = 1'b1;
                state_next = S_PRE_WR;
            end

            S_PRE_WR:
            begin
                cnt_we    = 1'b1;
                cnt_wdata = prefix_sum;
                acc_next  = prefix_sum;
                if (idx_reg == IDX_END)
                begin
                    idx_next   = IDX_W'(last_idx_reg);
                    state_next = S_PL_RD;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_PRE_RD;
                end
            end

            S_PL_RD:
            begin
                val_re     = 1'b1;
                state_next = S_PL_KEY;
            end

            S_PL_KEY:
            begin
                cnt_re     = 1'b1;
                cnt_raddr  = key;
                key_next   = key;
                state_next = S_PL_WR;
            end

            S_PL_WR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = key_reg;
                cnt_wdata = pos;
                srt_we    = 1'b1;
                if (idx_reg == '0)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    idx_next   = idx_reg - IDX_W'(1);
                    state_next = S_PL_RD;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = pend_kind_reg;
                    sval_next      = (pend_kind_reg == KIND_ELEMENT) ? $signed(srt_rdata) : '0;
                    final_next     = pend_final_reg;
                    rerr_next      = err_reg;
                    count_next     = (pend_kind_reg == KIND_STATUS) ?
                                     ITEM_COUNT_BITS'(held_reg) : '0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            held_reg      <= '0;
            min_reg       <= VAL_MAX;
            max_reg       <= VAL_MIN;
            fp_reg        <= '0;
            err_reg       <= 1'b0;
            done_reg      <= 1'b0;
            mz_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            held_reg      <= held_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            fp_reg        <= fp_next;
            err_reg       <= err_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                mz_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        last_idx_reg   <= last_idx_next;
        key_reg        <= key_next;
        acc_reg        <= acc_next;
        pend_kind_reg  <= pend_kind_next;
        pend_final_reg <= pend_final_next;
        kind_reg       <= kind_next;
        sval_reg       <= sval_next;
        final_reg      <= final_next;
        rerr_reg       <= rerr_next;
        count_reg      <= count_next;
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign sorted_value  = sval_reg;
    assign final_element = final_reg;
    assign range_error   = rerr_reg;
    assign item_count    = count_reg;

    a_fetch_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && operation == OP_FETCH) |=> !in_ready)
        else $error("block ready right after a fetch item");

    a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && operation == OP_LOAD && !last) |=> in_ready)
        else $error("load without last left the idle state");

    a_element_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_ELEMENT) |-> !range_error)
        else $error("element item delivered with error flag set");

    a_fetch_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fp_reg <= held_reg)
        else $error("fetch pointer beyond held item count");

endmodule

// ===== tb/sv/sorted_output_checker.sv =====
`timescale 1ns / 100ps

module sorted_output_checker (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_we,
    input  logic                                      cfg_wdata,
    input  logic                                      in_valid,
    input  logic                                      in_ready,
    input  logic                                      operation,
    input  logic signed [cse_pkg::DEF_VALUE_BITS-1:0] value,
    input  logic                                      last,
    input  logic                                      out_valid,
    input  logic                                      out_ready,
    input  logic [cse_pkg::KIND_BITS-1:0]             kind,
    input  logic signed [cse_pkg::DEF_VALUE_BITS-1:0] sorted_value,
    input  logic                                      final_element,
    input  logic                                      range_error,
    input  logic [cse_pkg::ITEM_COUNT_BITS-1:0]       item_count,
    output int                                        outstanding,
    output int                                        failures
);

    import cse_pkg::*;

    localparam int VB  = DEF_VALUE_BITS;
    localparam int MI  = DEF_MAX_ITEMS;
    localparam int CD  = DEF_COUNT_DEPTH;
    localparam int ICB = ITEM_COUNT_BITS;
    localparam int V_HI = (1 << (VB - 1)) - 1;
    localparam int V_LO = -(1 << (VB - 1));

    typedef struct {
        kind_t                kind;
        logic signed [VB-1:0] sval;
        logic                 fin;
        logic                 rerr;
        logic [ICB-1:0]       cnt;
    } sort_output_t;

    sort_output_t awaited_outputs[$];

    int held_vals [MI];
    int ordered_vals [MI];
    int key_counts [CD];
    int held_n;
    int ordered_n;
    int fetch_idx;
    int batch_lo;
    int batch_hi;
    int mismatch_n;
    bit batch_err;
    bit batch_sorted;
    bit zero_floor;

    function automatic void start_batch();
        held_n       = 0;
        ordered_n    = 0;
        fetch_idx    = 0;
        batch_lo     = V_HI;
        batch_hi     = V_LO;
        batch_err    = 1'b0;
        batch_sorted = 1'b0;
    endfunction

    function automatic void sort_batch();
        int floor_v;
        int key;
        int pos;
        floor_v = zero_floor ? 0 : batch_lo;
        foreach (key_counts[i])
            key_counts[i] = 0;
        ordered_n    = 0;
        fetch_idx    = 0;
        batch_sorted = 1'b1;
        if (zero_floor && batch_lo < 0)
            batch_err = 1'b1;
        if (batch_hi - floor_v + 1 > CD)
            batch_err = 1'b1;
        if (batch_err)
            return;
        for (int i = 0; i < held_n; i++)
        begin
            key = held_vals[i] - floor_v;
            if (key >= 0 && key < CD)
                key_counts[key]++;
        end
        for (int i = 1; i < CD; i++)
            key_counts[i] += key_counts[i-1];
        for (int i = held_n; i > 0; i--)
        begin
            key = held_vals[i-1] - floor_v;
            if (key >= 0 && key < CD && key_counts[key] > 0)
            begin
                key_counts[key]--;
                pos = key_counts[key];
                if (pos < MI)
                    ordered_vals[pos] = held_vals[i-1];
            end
        end
        ordered_n = held_n;
    endfunction

    function automatic void apply_load(int v, logic is_last);
        sort_output_t st;
        if (batch_sorted)
            start_batch();
        if (held_n < MI)
        begin
            held_vals[held_n] = v;
            held_n++;
            if (v < batch_lo)
                batch_lo = v;
            if (v > batch_hi)
                batch_hi = v;
        end
        else
            batch_err = 1'b1;
        if (is_last)
        begin
            sort_batch();
            st.kind = KIND_STATUS;
            st.sval = '0;
            st.fin  = 1'b0;
            st.rerr = batch_err;
            st.cnt  = ICB'(held_n);
            awaited_outputs.push_back(st);
        end
    endfunction

    function automatic void apply_fetch();
        sort_output_t st;
        st.kind = KIND_EMPTY;
        st.sval = '0;
        st.fin  = 1'b0;
        st.rerr = batch_err;
        st.cnt  = '0;
        if (batch_sorted && fetch_idx < ordered_n && fetch_idx < MI)
        begin
            st.kind = KIND_ELEMENT;
            st.sval = VB'(ordered_vals[fetch_idx]);
            st.fin  = (fetch_idx + 1 == ordered_n);
            fetch_idx++;
        end
        awaited_outputs.push_back(st);
    endfunction

    function automatic void check_output();
        sort_output_t want;
        if (awaited_outputs.size() == 0)
        begin
            mismatch_n++;
            if (mismatch_n <= 10)
                $display("%0t: unexpected item: kind %0d value %0d final %0b error %0b count %0d",
                         $realtime, kind, sorted_value, final_element, range_error, item_count);
            return;
        end
        want = awaited_outputs.pop_front();
        if (kind !== want.kind || sorted_value !== want.sval || final_element !== want.fin ||
            range_error !== want.rerr || item_count !== want.cnt)
        begin
            mismatch_n++;
            if (mismatch_n <= 10)
            begin
                $display("%0t: mismatch: expected kind %0d value %0d final %0b error %0b count %0d",
                         $realtime, want.kind, want.sval, want.fin, want.rerr, want.cnt);
                $display("%0t:           got kind %0d value %0d final %0b error %0b count %0d",
                         $realtime, kind, sorted_value, final_element, range_error, item_count);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_floor = 1'b0;
            start_batch();
            awaited_outputs.delete();
            mismatch_n  = 0;
            outstanding <= 0;
            failures    <= 0;
        end
        else
        begin
            if (cfg_we)
                zero_floor = cfg_wdata;
            if (in_valid && in_ready)
            begin
                if (operation == OP_LOAD)
                    apply_load(int'(value), last);
                else
                    apply_fetch();
            end
            if (out_valid && out_ready)
                check_output();
            outstanding <= awaited_outputs.size();
            failures    <= mismatch_n;
        end
    end

endmodule

// ===== tb/sv/counting_sort_engine_tb.sv =====
`timescale 1ns / 100ps

module counting_sort_engine_tb;

    import cse_pkg::*;

    localparam int VB = DEF_VALUE_BITS;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic                       cfg_wdata;
    logic                       in_valid;
    logic                       in_ready;
    logic                       operation;
    logic signed [VB-1:0]       value;
    logic                       last;
    logic                       out_valid;
    logic                       out_ready;
    logic [KIND_BITS-1:0]       kind;
    logic signed [VB-1:0]       sorted_value;
    logic                       final_element;
    logic                       range_error;
    logic [ITEM_COUNT_BITS-1:0] item_count;

    int outstanding;
    int failures;
    int items_sent;
    bit floor_zero;
    bit calm;

    counting_sort_engine i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .value         (value),
        .last          (last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .sorted_value  (sorted_value),
        .final_element (final_element),
        .range_error   (range_error),
        .item_count    (item_count)
    );

    sorted_output_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .value         (value),
        .last          (last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .sorted_value  (sorted_value),
        .final_element (final_element),
        .range_error   (range_error),
        .item_count    (item_count),
        .outstanding   (outstanding),
        .failures      (failures)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #100_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    initial
    begin
        int on_n;
        int off_n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            on_n = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
            @(posedge clk);
            out_ready <= 1'b1;
            repeat (on_n - 1) @(posedge clk);
            off_n = pick_gap();
            if (off_n > 0)
            begin
                @(posedge clk);
                out_ready <= 1'b0;
                repeat (off_n - 1) @(posedge clk);
            end
        end
    end

    task automatic send_item(input logic op, input int v, input logic lst);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        value     <= VB'(v);
        last      <= lst;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // hold off until every awaited item is back and the block has settled
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_floor_mode(input bit m);
        drain();
        cfg_we     <= 1'b1;
        cfg_wdata  <= m;
        floor_zero = m;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic fetch_n(input int n);
        for (int i = 0; i < n; i++)
            send_item(OP_FETCH, $urandom, 1'b0);
    endtask

    task automatic run_batch();
        int n;
        int span;
        int base;
        int flavor;
        int nfetch;
        int v;
        calm   = ($urandom_range(0, 4) == 0);
        n      = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 200) : $urandom_range(1, 12);
        flavor = $urandom_range(0, 19);
        case ($urandom_range(0, 3))
            0:       span = $urandom_range(1, 4);
            1:       span = DEF_COUNT_DEPTH;
            default: span = $urandom_range(1, DEF_COUNT_DEPTH);
        endcase
        base = floor_zero ? 0 : int'($urandom_range(0, 65536 - span)) - 32768;
        for (int k = 0; k < n; k++)
        begin
            if (flavor < 2)
                v = int'($urandom_range(0, 65535)) - 32768;
            else if (flavor == 2)
                v = int'($urandom_range(0, 1040)) - 16;
            else
                v = base + int'($urandom_range(0, span - 1));
            if (flavor == 3 && $urandom_range(0, 3) == 0)
                send_item(OP_FETCH, $urandom, 1'b0);
            send_item(OP_LOAD, v, k == n - 1);
        end
        nfetch = ($urandom_range(0, 9) < 7) ? n + $urandom_range(0, 2) : $urandom_range(0, n);
        for (int i = 0; i < nfetch; i++)
            send_item(OP_FETCH, $urandom, 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        int batch_n;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = 1'b0;
        in_valid   = 1'b0;
        operation  = OP_LOAD;
        value      = '0;
        last       = 1'b0;
        calm       = 1'b0;
        floor_zero = 1'b0;
        items_sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_floor_mode(1'b0);
        fetch_n(1);
        send_item(OP_LOAD, -32768, 1'b0);
        send_item(OP_LOAD, 32767, 1'b1);
        fetch_n(1);
        send_item(OP_LOAD, -32767, 1'b0);
        send_item(OP_LOAD, -32768, 1'b0);
        send_item(OP_LOAD, -32763, 1'b1);
        fetch_n(4);
        send_item(OP_LOAD, 32767, 1'b0);
        send_item(OP_LOAD, 31744, 1'b0);
        send_item(OP_LOAD, 32000, 1'b1);
        fetch_n(3);
        send_item(OP_LOAD, 0, 1'b1);
        fetch_n(2);

        // overflow the buffer: the load with last is dropped but still closes the batch with an error status
        calm = 1'b1;
        for (int i = 0; i < DEF_MAX_ITEMS; i++)
            send_item(OP_LOAD, int'($urandom_range(0, 63)) - 32, 1'b0);
        send_item(OP_LOAD, 7, 1'b1);
        fetch_n(1);
        calm = 1'b0;

        set_floor_mode(1'b1);
        send_item(OP_LOAD, 1023, 1'b0);
        send_item(OP_LOAD, 0, 1'b0);
        send_item(OP_LOAD, 5, 1'b0);
        send_item(OP_LOAD, 5, 1'b1);
        fetch_n(4);
        send_item(OP_LOAD, -1, 1'b0);
        send_item(OP_LOAD, 3, 1'b1);
        fetch_n(1);
        send_item(OP_LOAD, 1024, 1'b1);
        fetch_n(1);

        items_sent = 0;
        batch_n    = 0;
        while (items_sent < 450)
        begin
            if (batch_n % 4 == 3)
                set_floor_mode(1'($urandom_range(0, 1)));
            run_batch();
            batch_n++;
        end

        drain();
        repeat (30) @(posedge clk);
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/cse_pkg.sv
rtl/cse_ram.sv
rtl/counting_sort_engine.sv
tb/sv/sorted_output_checker.sv
tb/sv/counting_sort_engine_tb.sv
